// ===== rtl/oli_pkg.sv =====
`default_nettype none
package oli_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic [1:0]         mode;
        logic [POS_W-1:0]   position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [3:0] found_index;
        logic [4:0] length;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic take_lo;
        logic take_hi;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== rtl/oli_cell.sv =====
`default_nettype none
module oli_cell (
    input  wire logic               i_clk,
    input  wire oli_pkg::t_cell_ctl i_ctl,
    input  wire oli_pkg::t_word     i_lo,
    input  wire oli_pkg::t_word     i_hi,
    input  wire oli_pkg::t_word     i_key,
    input  wire logic               i_live,
    output oli_pkg::t_word          o_word,
    output logic                    o_match
);
    import oli_pkg::*;

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.load) begin
            n_word = i_key;
        end else if (i_ctl.take_lo) begin
            n_word = i_lo;
        end else if (i_ctl.take_hi) begin
            n_word = i_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    assign o_match = i_live && (r_word == i_key);

endmodule
`default_nettype wire

// ===== rtl/oli_first.sv =====
`default_nettype none
module oli_first (
    input  wire logic [oli_pkg::DEPTH-1:0] i_match,
    output logic                           o_hit,
    output logic [oli_pkg::IDX_W-1:0]      o_index
);
    import oli_pkg::*;

    // scan from the top so the lowest matching cell wins
    always_comb begin
        o_hit   = 1'b0;
        o_index = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_hit   = 1'b1;
                o_index = IDX_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ordered_list_insert_delete_search.sv =====
`default_nettype none
// channel | valid      | stall       | payload
// --------+------------+-------------+----------------------------
// request | i_in_valid | o_in_stall  | i_in_data  (oli_pkg::t_req)
// result  | o_out_valid| i_out_stall | o_out_data (oli_pkg::t_rsp)
//
// All cells shift or compare in parallel and the first-match encoder over the cell row
// settles the search in the same cycle as the request is accepted.
// The result register loads the answer at the accepting edge and offers it the next cycle.
// A new request is taken whenever the result register is empty or being drained.
// Synchronous active-low reset empties the list; stored words are not cleared.
module ordered_list_insert_delete_search (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire oli_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output oli_pkg::t_rsp      o_out_data
);
    import oli_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_rsp             r_out;
    t_rsp             n_out;

    logic             acc;
    logic             full;
    logic             ins_ok;
    logic             del_ok;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] cnt;
    t_word            key;
    t_word            words [DEPTH];
    logic [DEPTH-1:0] match;
    logic             hit;
    logic [IDX_W-1:0] hit_index;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign acc        = i_in_valid && !o_in_stall;
    assign key        = DATA_WIDTH'(i_in_data.value);
    assign pos        = CMP_W'(i_in_data.position);
    assign cnt        = CMP_W'(r_count);
    assign full       = r_count == CNT_W'(DEPTH);
    assign ins_ok     = acc && (i_in_data.mode == MODE_INSERT) && !full && (pos <= cnt);
    assign del_ok     = acc && (i_in_data.mode == MODE_DELETE) && (pos < cnt);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl ctl;
        t_word     lo;
        t_word     hi;

        assign ctl.load    = ins_ok && (pos == CMP_W'(g));
        assign ctl.take_lo = ins_ok && (pos < CMP_W'(g));
        assign ctl.take_hi = del_ok && (pos <= CMP_W'(g)) && (g < DEPTH - 1);

        if (g == 0) begin : g_lo_end
            assign lo = key;
        end else begin : g_lo
            assign lo = words[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi_end
            assign hi = key;
        end else begin : g_hi
            assign hi = words[g+1];
        end

        oli_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_lo    (lo),
            .i_hi    (hi),
            .i_key   (key),
            .i_live  (CMP_W'(g) < cnt),
            .o_word  (words[g]),
            .o_match (match[g])
        );
    end

    oli_first u_first (
        .i_match (match),
        .o_hit   (hit),
        .o_index (hit_index)
    );

    always_comb begin
        n_count           = r_count;
        n_out.status      = ST_OK;
        n_out.found       = 1'b0;
        n_out.found_index = '0;
        case (i_in_data.mode)
            MODE_INSERT: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else if (!ins_ok) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            MODE_DELETE: begin
                if (!del_ok) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            MODE_SEARCH: begin
                n_out.found       = hit;
                n_out.found_index = hit ? 4'(hit_index) : 4'd0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (!acc) begin
            n_count = r_count;
        end
        n_out.length = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_ok |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted insert did not grow the list");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FULL) |-> full)
        else $error("full status while list not full");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.found) |-> (r_out.found_index < r_out.length))
        else $error("search hit beyond list length");

endmodule
`default_nettype wire

// ===== tb/ordered_list_insert_delete_search_test.sv =====
`default_nettype none
module ordered_list_insert_delete_search_test;
    import oli_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int POS_MAX = (1 << POS_W) - 1;
    localparam int CYCLE_LIMIT = 100000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_stall;
    t_req  i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_rsp  o_out_data;

    // shadow copy of the list contents
    t_word shadow_words [DEPTH];
    int    shadow_len = 0;
    t_rsp  answers_due [$];

    int error_count = 0;
    int cycle_count = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_request = 0;
    int hold_left = 0;
    bit grow_phase = 1'b0;

    ordered_list_insert_delete_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Apply one request to the shadow list and return the answer it must produce.
    function automatic t_rsp list_op_answer(t_req req);
        t_rsp  rsp;
        t_word key;
        int    i;
        rsp = '0;
        key = t_word'(req.value);
        case (req.mode)
            MODE_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (req.position > shadow_len) begin
                    rsp.status = ST_RANGE;
                end else begin
                    for (i = shadow_len; i > req.position; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[req.position] = key;
                    shadow_len++;
                end
            end
            MODE_DELETE: begin
                if (req.position >= shadow_len) begin
                    rsp.status = ST_RANGE;
                end else begin
                    for (i = req.position; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            MODE_SEARCH: begin
                // scan downward so the lowest hit wins
                for (i = shadow_len - 1; i >= 0; i--) begin
                    if (shadow_words[i] == key) begin
                        rsp.found = 1'b1;
                        rsp.found_index = 4'(i);
                    end
                end
            end
            default: ;
        endcase
        rsp.length = 5'(shadow_len);
        return rsp;
    endfunction

    function automatic t_req make_req(logic [1:0] mode, int pos, logic [31:0] val);
        t_req req;
        req.mode = mode;
        req.position = POS_W'(pos);
        req.value = val;
        return req;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4, 5, 6: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Offer one transaction, hold it until accepted, return at the falling edge.
    task automatic send_req(input t_req req);
        int gap;
        if (tx_idle_en && $urandom_range(99) < 16) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        answers_due.push_back(list_op_answer(req));
        @(negedge i_clk);
    endtask

    task automatic send_random_op();
        int len;
        int roll;
        int ins_pct;
        int del_pct;
        len = shadow_len;
        if ($urandom_range(99) < 10) begin
            case ($urandom_range(0, 3))
                0: send_req(make_req(MODE_UNUSED, $urandom_range(0, POS_MAX), $urandom));
                1: send_req(make_req(MODE_INSERT, $urandom_range(len + 1, POS_MAX),
                                     pick_word()));
                2: send_req(make_req(MODE_DELETE, $urandom_range(len, POS_MAX), $urandom));
                default: send_req(make_req(MODE_SEARCH, $urandom_range(0, POS_MAX),
                                           $urandom));
            endcase
        end else begin
            ins_pct = grow_phase ? 55 : 20;
            del_pct = grow_phase ? 20 : 55;
            roll = $urandom_range(99);
            if (roll < ins_pct) begin
                send_req(make_req(MODE_INSERT, $urandom_range(0, len), pick_word()));
            end else if (roll < ins_pct + del_pct) begin
                send_req(make_req(MODE_DELETE, (len == 0) ? 0 : $urandom_range(0, len - 1),
                                  $urandom));
            end else if (len > 0 && $urandom_range(0, 1) == 1) begin
                send_req(make_req(MODE_SEARCH, $urandom_range(0, POS_MAX),
                                  shadow_words[$urandom_range(0, len - 1)]));
            end else begin
                send_req(make_req(MODE_SEARCH, $urandom_range(0, POS_MAX), pick_word()));
            end
        end
    endtask

    task automatic test_directed();
        send_req(make_req(MODE_SEARCH, 0, 32'd5));
        send_req(make_req(MODE_DELETE, 0, 32'd0));
        send_req(make_req(MODE_INSERT, 1, 32'd9));
        send_req(make_req(MODE_INSERT, 0, 32'h7fff_ffff));
        send_req(make_req(MODE_INSERT, 0, 32'h8000_0000));
        send_req(make_req(MODE_INSERT, 2, 32'h0));
        send_req(make_req(MODE_INSERT, 1, 32'hffff_ffff));
        send_req(make_req(MODE_INSERT, 4, 32'h8000_0000));
        send_req(make_req(MODE_INSERT, POS_MAX, 32'd1));
        send_req(make_req(MODE_SEARCH, 0, 32'h8000_0000));
        send_req(make_req(MODE_SEARCH, 7, 32'hffff_ffff));
        send_req(make_req(MODE_SEARCH, POS_MAX, 32'd12345));
        send_req(make_req(MODE_UNUSED, POS_MAX, 32'hffff_ffff));
        send_req(make_req(MODE_DELETE, 5, 32'd0));
        send_req(make_req(MODE_DELETE, POS_MAX, 32'hffff_ffff));
        send_req(make_req(MODE_DELETE, 4, 32'd0));
        send_req(make_req(MODE_DELETE, 0, 32'd0));
        send_req(make_req(MODE_SEARCH, 0, 32'h8000_0000));
    endtask

    task automatic test_full_list();
        while (shadow_len < DEPTH)
            send_req(make_req(MODE_INSERT, $urandom_range(0, shadow_len), pick_word()));
        // full takes priority over a bad position
        send_req(make_req(MODE_INSERT, POS_MAX, 32'd3));
        send_req(make_req(MODE_INSERT, 0, 32'd3));
        send_req(make_req(MODE_SEARCH, 0, shadow_words[DEPTH-1]));
        send_req(make_req(MODE_DELETE, DEPTH - 1, 32'd0));
        send_req(make_req(MODE_DELETE, DEPTH - 1, 32'd0));
        while (shadow_len > 0)
            send_req(make_req(MODE_DELETE, $urandom_range(0, shadow_len - 1), $urandom));
        send_req(make_req(MODE_DELETE, 0, 32'd0));
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0)
                grow_phase = ~grow_phase;
            send_random_op();
        end
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random(120);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_request = 60;
        test_random(20);
        tx_idle_en = 1'b1;
    endtask

    // receiver: long hold-off on request, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (rx_idle_en && $urandom_range(99) < 16) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_due.size() == 0) begin
                $error("unexpected result transaction: %p", o_out_data);
                error_count++;
            end else begin
                want = answers_due.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.found !== want.found) begin
                    $error("found expected %0d actual %0d", want.found, o_out_data.found);
                    error_count++;
                end
                if (o_out_data.found_index !== want.found_index) begin
                    $error("found_index expected %0d actual %0d",
                           want.found_index, o_out_data.found_index);
                    error_count++;
                end
                if (o_out_data.length !== want.length) begin
                    $error("length expected %0d actual %0d", want.length, o_out_data.length);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_list();
        test_random(300);
        test_back_to_back();
        test_backpressure();
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
